FILE: hdl/cperim_pkg.sv
package cperim_pkg;

	// field widths
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int RAD_W   = 10;
	localparam int SQ_W    = 2 * RAD_W;

	// mirrored points per step
	localparam int NUM_PTS = 8;

	// queue between front and back
	localparam int QDEPTH = 16;
	localparam int Q_AW   = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// parameter defaults
	localparam int DEF_MAX_DIM    = 4096;
	localparam int DEF_MAX_RADIUS = 1023;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
	localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(480);
	localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(640);

	// which signed offset a coordinate of a mirrored point takes
	typedef enum logic [1:0] {
		OFF_PI,
		OFF_PH,
		OFF_MH,
		OFF_MI
	} off_sel_t;

	// point order: (i,h) (h,i) (h,-i) (i,-h) (-i,-h) (-h,-i) (-h,i) (-i,h)
	localparam off_sel_t ROW_SEL [NUM_PTS] = '{
		OFF_PI, OFF_PH, OFF_PH, OFF_PI, OFF_MI, OFF_MH, OFF_MH, OFF_MI
	};
	localparam off_sel_t COL_SEL [NUM_PTS] = '{
		OFF_PH, OFF_PI, OFF_MI, OFF_MH, OFF_MH, OFF_MI, OFF_PI, OFF_PH
	};

	// sideband carried along the square root pipeline
	typedef struct packed {
		logic [COORD_W-1:0] crow;
		logic [COORD_W-1:0] ccol;
		logic [RAD_W-1:0]   step;
		logic               active;
	} cperim_side_t;

	// one classified step, as queued for the back end
	typedef struct packed {
		logic [COORD_W-1:0] crow;
		logic [COORD_W-1:0] ccol;
		logic [RAD_W-1:0]   step;
		logic [RAD_W-1:0]   h;
		logic [NUM_PTS-1:0] mask;
	} cperim_item_t;

endpackage

FILE: hdl/cperim_sqrt.sv
module cperim_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [cperim_pkg::SQ_W-1:0]       n,
	input  cperim_pkg::cperim_side_t          in_side,
	output logic                              out_vld,
	output logic [cperim_pkg::RAD_W-1:0]      root,
	output logic [cperim_pkg::RAD_W:0]        rem,
	output cperim_pkg::cperim_side_t          out_side
);
	import cperim_pkg::*;

	// one result bit per stage, restoring digit method
	logic                 vld_s  [RAD_W];
	logic [RAD_W:0]       rem_s  [RAD_W];
	logic [RAD_W-1:0]     root_s [RAD_W];
	logic [SQ_W-1:0]      n_s    [RAD_W];
	cperim_side_t         side_s [RAD_W];

	for (genvar k = 0; k < RAD_W; k++) begin : g_stage
		logic               cur_vld;
		logic [RAD_W:0]     cur_rem;
		logic [RAD_W-1:0]   cur_root;
		logic [SQ_W-1:0]    cur_n;
		cperim_side_t       cur_side;
		logic [RAD_W+2:0]   work;
		logic [RAD_W+2:0]   trial;
		logic [RAD_W+2:0]   diff;
		logic               take;

		if (k == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_n    = n;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_n    = n_s[k-1];
			assign cur_side = side_s[k-1];
		end

		assign work  = {cur_rem, cur_n[SQ_W-1 -: 2]};
		assign trial = {1'b0, cur_root, 2'b01};
		assign diff  = work - trial;
		assign take  = (work >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? diff[RAD_W:0] : work[RAD_W:0];
			root_s[k] <= {cur_root[RAD_W-2:0], take};
			n_s[k]    <= cur_n << 2;
			side_s[k] <= cur_side;
		end
	end

	assign out_vld  = vld_s[RAD_W-1];
	assign root     = root_s[RAD_W-1];
	assign rem      = rem_s[RAD_W-1];
	assign out_side = side_s[RAD_W-1];

endmodule

FILE: hdl/cperim_front.sv
module cperim_front #(
	parameter int MAX_RADIUS = cperim_pkg::DEF_MAX_RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cperim_pkg::COORD_W-1:0]    center_row,
	input  logic [cperim_pkg::COORD_W-1:0]    center_col,
	input  logic [cperim_pkg::RAD_W-1:0]      radius,
	input  logic [cperim_pkg::RAD_W-1:0]      step_index,
	input  logic [cperim_pkg::DIM_W-1:0]      rows_lim,
	input  logic [cperim_pkg::DIM_W-1:0]      cols_lim,
	input  logic [cperim_pkg::QCNT_W-1:0]     q_level,
	output logic                              push,
	output cperim_pkg::cperim_item_t          push_item
);
	import cperim_pkg::*;

	localparam int RAD_MAX_W = 2 ** RAD_W - 1;
	localparam int RAD_LIM   = (MAX_RADIUS < RAD_MAX_W) ? MAX_RADIUS : RAD_MAX_W;
	localparam logic [RAD_W-1:0] RAD_CAP = RAD_W'(RAD_LIM);

	function automatic logic pos_ok(
		input logic [COORD_W-1:0] c,
		input logic [RAD_W-1:0]   x,
		input logic [DIM_W-1:0]   lim
	);
		logic [DIM_W-1:0] s;
		s = DIM_W'(c) + DIM_W'(x);
		return s < lim;
	endfunction

	function automatic logic neg_ok(
		input logic [COORD_W-1:0] c,
		input logic [RAD_W-1:0]   x,
		input logic [DIM_W-1:0]   lim
	);
		logic [COORD_W-1:0] d;
		d = c - COORD_W'(x);
		return (c >= COORD_W'(x)) && (DIM_W'(d) < lim);
	endfunction

	logic                 fire;
	logic                 exit_s4;
	logic [QCNT_W-1:0]    pend_q;
	logic [QCNT_W:0]      used;
	logic [RAD_W-1:0]     r_eff;
	logic [SQ_W-1:0]      rr_c;
	logic [SQ_W-1:0]      ii_c;

	logic                 vld_s1;
	logic [SQ_W-1:0]      rr_s1;
	logic [SQ_W-1:0]      ii_s1;
	cperim_side_t         side_s1;

	logic                 vld_s2;
	logic [SQ_W-1:0]      n_s2;
	cperim_side_t         side_s2;

	logic                 sq_vld;
	logic [RAD_W-1:0]     sq_root;
	logic [RAD_W:0]       sq_rem;
	cperim_side_t         sq_side;

	logic                 vld_s3;
	logic [RAD_W-1:0]     h_s3;
	cperim_side_t         side_s3;

	logic [3:0]           row_ok;
	logic [3:0]           col_ok;
	logic [NUM_PTS-1:0]   mask_c;

	logic                 vld_s4;
	logic                 keep_s4;
	cperim_item_t         item_s4;

	// items in the pipeline plus items queued never exceed the queue depth
	assign used     = {1'b0, pend_q} + {1'b0, q_level};
	assign in_ready = (used < (QCNT_W + 1)'(QDEPTH));
	assign fire     = in_valid & in_ready;
	assign exit_s4  = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + QCNT_W'(fire) - QCNT_W'(exit_s4);
		end
	end

	// stage 1: squares and active test
	assign r_eff = (radius > RAD_CAP) ? RAD_CAP : radius;
	assign rr_c  = {{RAD_W{1'b0}}, r_eff} * {{RAD_W{1'b0}}, r_eff};
	assign ii_c  = {{RAD_W{1'b0}}, step_index} * {{RAD_W{1'b0}}, step_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= fire;
			vld_s2 <= vld_s1;
			vld_s3 <= sq_vld;
			vld_s4 <= vld_s3;
		end
	end

	// stage 2: radicand
	always_ff @(posedge clk) begin
		rr_s1          <= rr_c;
		ii_s1          <= ii_c;
		side_s1.crow   <= center_row;
		side_s1.ccol   <= center_col;
		side_s1.step   <= step_index;
		side_s1.active <= ({ii_c, 1'b0} <= {1'b0, rr_c});

		n_s2           <= rr_s1 - ii_s1;
		side_s2        <= side_s1;
	end

	cperim_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.n        (n_s2),
		.in_side  (side_s2),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.rem      (sq_rem),
		.out_side (sq_side)
	);

	// stage 3: round to nearest, up when remainder exceeds the floor root
	always_ff @(posedge clk) begin
		h_s3    <= sq_root + RAD_W'(sq_rem > {1'b0, sq_root});
		side_s3 <= sq_side;
	end

	// stage 4: bounds of the eight mirrored points
	always_comb begin
		row_ok[OFF_PI] = pos_ok(side_s3.crow, side_s3.step, rows_lim);
		row_ok[OFF_PH] = pos_ok(side_s3.crow, h_s3, rows_lim);
		row_ok[OFF_MH] = neg_ok(side_s3.crow, h_s3, rows_lim);
		row_ok[OFF_MI] = neg_ok(side_s3.crow, side_s3.step, rows_lim);
		col_ok[OFF_PI] = pos_ok(side_s3.ccol, side_s3.step, cols_lim);
		col_ok[OFF_PH] = pos_ok(side_s3.ccol, h_s3, cols_lim);
		col_ok[OFF_MH] = neg_ok(side_s3.ccol, h_s3, cols_lim);
		col_ok[OFF_MI] = neg_ok(side_s3.ccol, side_s3.step, cols_lim);
		for (int k = 0; k < NUM_PTS; k++) begin
			mask_c[k] = row_ok[ROW_SEL[k]] & col_ok[COL_SEL[k]];
		end
	end

	always_ff @(posedge clk) begin
		keep_s4        <= side_s3.active && (mask_c != '0);
		item_s4.crow   <= side_s3.crow;
		item_s4.ccol   <= side_s3.ccol;
		item_s4.step   <= side_s3.step;
		item_s4.h      <= h_s3;
		item_s4.mask   <= mask_c;
	end

	// steps with no surviving point never reach the queue
	assign push      = vld_s4 & keep_s4;
	assign push_item = item_s4;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= (QCNT_W + 1)'(QDEPTH))
		else $error("front credit count exceeds queue depth");

endmodule

FILE: hdl/cperim_fifo.sv
module cperim_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  cperim_pkg::cperim_item_t          push_item,
	input  logic                              pop,
	output cperim_pkg::cperim_item_t          pop_item,
	output logic                              not_empty,
	output logic [cperim_pkg::QCNT_W-1:0]     level
);
	import cperim_pkg::*;

	cperim_item_t        mem [QDEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [Q_AW-1:0]     rd_addr;
	cperim_item_t        head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// head entry after this edge, written entry forwarded when it becomes the head
	assign rd_addr = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
		if (push && (wr_ptr_q == rd_addr)) begin
			head_q <= push_item;
		end else begin
			head_q <= mem[rd_addr];
		end
	end

	assign pop_item  = head_q;
	assign not_empty = (cnt_q != '0);
	assign level     = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < QCNT_W'(QDEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue read while empty");

endmodule

FILE: hdl/cperim_back.sv
module cperim_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  cperim_pkg::cperim_item_t          q_item,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cperim_pkg::COORD_W-1:0]    point_row,
	output logic [cperim_pkg::COORD_W-1:0]    point_col,
	output logic                              last_point
);
	import cperim_pkg::*;

	localparam int PT_W = $clog2(NUM_PTS);

	function automatic logic [COORD_W-1:0] offset(
		input logic [COORD_W-1:0] c,
		input logic [RAD_W-1:0]   step,
		input logic [RAD_W-1:0]   h,
		input off_sel_t           sel
	);
		logic [COORD_W-1:0] r;
		unique case (sel)
			OFF_PI: r = c + COORD_W'(step);
			OFF_PH: r = c + COORD_W'(h);
			OFF_MH: r = c - COORD_W'(h);
			OFF_MI: r = c - COORD_W'(step);
		endcase
		return r;
	endfunction

	cperim_item_t          cur_q;
	logic [NUM_PTS-1:0]    mask_q;
	logic                  cur_vld_q;
	logic                  out_vld_q;
	logic [COORD_W-1:0]    row_q;
	logic [COORD_W-1:0]    col_q;
	logic                  last_q;

	logic                  slot_free;
	logic                  emit;
	logic                  done;
	logic [PT_W-1:0]       sel;
	logic [NUM_PTS-1:0]    rest;

	// lowest pending point first
	always_comb begin
		sel = '0;
		for (int k = NUM_PTS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				sel = PT_W'(k);
			end
		end
	end

	assign rest      = mask_q & (mask_q - 1'b1);
	assign slot_free = !out_vld_q || out_ready;
	assign emit      = cur_vld_q && slot_free;
	assign done      = emit && (rest == '0);
	assign q_pop     = q_valid && (!cur_vld_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
			end else if (done) begin
				cur_vld_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_item;
			mask_q <= q_item.mask;
		end else if (emit) begin
			mask_q <= rest;
		end
		if (emit) begin
			row_q  <= offset(cur_q.crow, cur_q.step, cur_q.h, ROW_SEL[sel]);
			col_q  <= offset(cur_q.ccol, cur_q.step, cur_q.h, COL_SEL[sel]);
			last_q <= (rest == '0);
		end
	end

	assign out_valid  = out_vld_q;
	assign point_row  = row_q;
	assign point_col  = col_q;
	assign last_point = last_q;

	a_cur_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> (mask_q != '0))
		else $error("active step holds no pending point");

endmodule

FILE: hdl/circle_perimeter_points.sv
// Perimeter point generator for circle Hough voting. Each input transfer names a circle
// (center_row, center_col, radius) and one octant step i; the block works out
// h = round(sqrt(r*r - i*i)) and sends out the eight mirrored points center+(i,h), (h,i),
// (h,-i), (i,-h), (-i,-h), (-h,-i), (-h,i), (-i,h) in that order, one point per output
// transfer, skipping any point outside the image set by image_rows and image_cols;
// last_point marks the final point of a step. A step with 2*i*i > r*r, or whose points
// all fall outside, gives no output transfer. Radius is clamped to MAX_RADIUS and the
// image size to MAX_DIM. Input transfers are taken one per cycle while the 16-entry step
// queue has room; the output side sends one point per cycle while out_ready is high,
// through the single output register, so a step takes one output transfer for each of
// its in-bounds points (up to eight). Each step passes through the ten-stage square root
// pipeline (one root bit per stage). Configuration writes are taken any cycle with
// cfg_we high and should only be made while the block is idle.
module circle_perimeter_points #(
	parameter int MAX_DIM    = cperim_pkg::DEF_MAX_DIM,
	parameter int MAX_RADIUS = cperim_pkg::DEF_MAX_RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// register writes
	input  logic                              cfg_we,
	input  logic [cperim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cperim_pkg::DIM_W-1:0]      cfg_data,

	// step input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cperim_pkg::COORD_W-1:0]    center_row,
	input  logic [cperim_pkg::COORD_W-1:0]    center_col,
	input  logic [cperim_pkg::RAD_W-1:0]      radius,
	input  logic [cperim_pkg::RAD_W-1:0]      step_index,

	// point output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cperim_pkg::COORD_W-1:0]    point_row,
	output logic [cperim_pkg::COORD_W-1:0]    point_col,
	output logic                              last_point
);
	import cperim_pkg::*;

	// image size clamp, also limited by what the size registers can hold
	localparam int DIM_MAX_W = 2 ** DIM_W - 1;
	localparam int DIM_LIM   = (MAX_DIM < DIM_MAX_W) ? MAX_DIM : DIM_MAX_W;
	localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_LIM);

	logic [DIM_W-1:0]    image_rows_q;
	logic [DIM_W-1:0]    image_cols_q;
	logic [DIM_W-1:0]    rows_lim;
	logic [DIM_W-1:0]    cols_lim;

	// front to queue
	logic                q_push;
	cperim_item_t        q_push_item;
	logic [QCNT_W-1:0]   q_level;

	// queue to back
	logic                q_pop;
	logic                q_valid;
	cperim_item_t        q_pop_item;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= ROWS_RESET;
			image_cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: image_rows_q <= cfg_data;
				CFG_COLS: image_cols_q <= cfg_data;
			endcase
		end
	end

	assign rows_lim = (image_rows_q > DIM_CAP) ? DIM_CAP : image_rows_q;
	assign cols_lim = (image_cols_q > DIM_CAP) ? DIM_CAP : image_cols_q;

	// front: squares, square root, rounding and bounds mask per step
	cperim_front #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_row (center_row),
		.center_col (center_col),
		.radius     (radius),
		.step_index (step_index),
		.rows_lim   (rows_lim),
		.cols_lim   (cols_lim),
		.q_level    (q_level),
		.push       (q_push),
		.push_item  (q_push_item)
	);

	// step queue, front reserves a slot for every step in flight
	cperim_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.not_empty (q_valid),
		.level     (q_level)
	);

	// back: walks the in-bounds mask, one point per output transfer
	cperim_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_pop_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_row  (point_row),
		.point_col  (point_col),
		.last_point (last_point)
	);

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cperim_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 40;   // well past the input to point latency
	localparam int HOLD_CYCLES   = 400;  // long receiver hold, fills the step queue
	localparam int ERR_SHOWN     = 10;

	// one step as offered on the input channel
	typedef struct packed {
		logic [COORD_W-1:0] crow;
		logic [COORD_W-1:0] ccol;
		logic [RAD_W-1:0]   rad;
		logic [RAD_W-1:0]   step;
	} step_t;

	// one perimeter point as seen on the output channel
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [DIM_W-1:0]   cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [COORD_W-1:0] center_row = '0;
	logic [COORD_W-1:0] center_col = '0;
	logic [RAD_W-1:0]   radius = '0;
	logic [RAD_W-1:0]   step_index = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COORD_W-1:0] point_row;
	logic [COORD_W-1:0] point_col;
	logic               last_point;

	// steps waiting to be offered, points waiting to come out
	step_t  steps_pending[$];
	point_t points_due[$];
	step_t  next_step;
	point_t want_pt;

	// our own copy of the size registers, as written (13 bit)
	int image_rows = 480;
	int image_cols = 640;

	// idle odds in percent, changed per phase
	int tx_idle_pct = 34;
	int rx_idle_pct = 63;

	// long receiver hold, requested once from the sequence
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	int          mismatch_count = 0;
	int unsigned cycle_count = 0;

	circle_perimeter_points i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_row (center_row),
		.center_col (center_col),
		.radius     (radius),
		.step_index (step_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_row  (point_row),
		.point_col  (point_col),
		.last_point (last_point)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// floor of the square root, one root bit per pass
	function automatic int root_floor(input int v);
		int root;
		int trial;
		root = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// image size as the block uses it: saturated at the largest dimension
	function automatic int dim_limit(input int v);
		return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : v;
	endfunction

	// expected points of one accepted step, appended to points_due
	task automatic rasterize_step(input step_t s);
		int     r, i, h, n, rsq, rows, cols, crow, ccol, pr, pc;
		int     dr[8];
		int     dc[8];
		point_t pts[$];
		point_t pt;
		r = s.rad;
		i = s.step;
		crow = s.crow;
		ccol = s.ccol;
		rsq = r * r;
		// steps past the octant boundary give nothing
		if (2 * i * i > rsq)
			return;
		// round to nearest: bump the floor when n lies above h*h + h
		n = rsq - i * i;
		h = root_floor(n);
		if (n > h * h + h)
			h++;
		rows = dim_limit(image_rows);
		cols = dim_limit(image_cols);
		// (i,h) (h,i) (h,-i) (i,-h) (-i,-h) (-h,-i) (-h,i) (-i,h)
		dr = '{i, h, h, i, -i, -h, -h, -i};
		dc = '{h, i, -i, -h, -h, -i, i, h};
		for (int k = 0; k < 8; k++) begin
			pr = crow + dr[k];
			pc = ccol + dc[k];
			// out of image points are dropped, duplicates stay
			if (pr >= 0 && pr < rows && pc >= 0 && pc < cols) begin
				pt = '{row: COORD_W'(pr), col: COORD_W'(pc), last: 1'b0};
				pts.insert(pts.size(), pt);
			end
		end
		if (pts.size() != 0)
			pts[pts.size()-1].last = 1'b1;
		foreach (pts[k])
			points_due.insert(points_due.size(), pts[k]);
	endtask

	// random step: mostly active steps with centers inside the image, some pure noise
	function automatic step_t rand_step();
		step_t s;
		int    pick, r;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// full range noise, mostly inactive steps and far centers
			s.crow = COORD_W'($urandom);
			s.ccol = COORD_W'($urandom);
			s.rad  = RAD_W'($urandom_range(1, 1023));
			s.step = RAD_W'($urandom);
		end else begin
			r = (pick < 20) ? $urandom_range(64, 1023) : $urandom_range(1, 63);
			s.rad  = RAD_W'(r);
			// largest active step is floor(sqrt(r*r/2))
			s.step = RAD_W'($urandom_range(0, root_floor((r * r) / 2)));
			s.crow = COORD_W'($urandom_range(0, dim_limit(image_rows) - 1));
			s.ccol = COORD_W'($urandom_range(0, dim_limit(image_cols) - 1));
		end
		return s;
	endfunction

	task automatic flag_error(input string what);
		mismatch_count++;
		if (mismatch_count <= ERR_SHOWN)
			$display("%0t: %s", $realtime, what);
	endtask

	// input driver: predicts each accepted step, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			center_row <= '0;
			center_col <= '0;
			radius     <= '0;
			step_index <= '0;
		end else begin
			if (in_valid && in_ready)
				rasterize_step('{crow: center_row, ccol: center_col,
					rad: radius, step: step_index});
			// payload may only move once the current transfer has happened
			if (!in_valid || in_ready) begin
				if (steps_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_step = steps_pending.pop_front();
					in_valid   <= 1'b1;
					center_row <= next_step.crow;
					center_col <= next_step.ccol;
					radius     <= next_step.rad;
					step_index <= next_step.step;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: checks each point transfer against the oldest expected point
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_taken <= 1'b0;
			hold_left  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (points_due.size() == 0) begin
					flag_error($sformatf("point (%0d,%0d) last=%0b with nothing expected",
						point_row, point_col, last_point));
				end else begin
					want_pt = points_due.pop_front();
					if (point_row !== want_pt.row || point_col !== want_pt.col ||
							last_point !== want_pt.last)
						flag_error($sformatf(
							"point expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
							want_pt.row, want_pt.col, want_pt.last,
							point_row, point_col, last_point));
				end
			end
			// long hold counted here, random stalls otherwise
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// sender pause: wait until every step is taken and every point has come out
	task automatic wait_drained();
		while (steps_pending.size() != 0 || in_valid || points_due.size() != 0)
			@(posedge clk);
	endtask

	// size writes only while idle; steps with no points may still be in flight
	task automatic set_image_size(input int rows, input int cols);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= DIM_W'(rows);
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= DIM_W'(cols);
		@(posedge clk);
		cfg_we <= 1'b0;
		image_rows = rows & 'h1FFF;
		image_cols = cols & 'h1FFF;
	endtask

	task automatic add_step(input step_t s);
		steps_pending.insert(steps_pending.size(), s);
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			add_step(rand_step());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed steps at the reset size of 480 x 640
		add_step('{240, 320, 1, 0});       // smallest radius
		add_step('{240, 320, 0, 0});       // zero radius: eight copies of center
		add_step('{240, 320, 0, 1});       // zero radius, later step: nothing
		add_step('{0, 0, 1023, 0});        // corner center, largest radius
		add_step('{4095, 4095, 1023, 723});// far center, all points dropped
		add_step('{479, 639, 1023, 1023}); // largest step, inactive
		add_step('{100, 200, 10, 7});      // last active step of r=10
		add_step('{100, 200, 10, 8});      // first inactive step of r=10
		add_step('{300, 300, 1023, 723});  // last active step of max radius
		add_step('{300, 300, 1023, 724});  // just past the octant boundary
		add_step('{0, 639, 5, 3});         // clipped on top and right edges
		add_step('{479, 0, 5, 0});         // clipped on bottom and left edges
		add_step('{2730, 1365, 682, 341}); // alternating bit patterns
		add_step('{200, 300, 3, 2});       // h equals i: duplicate points
		add_step('{50, 50, 17, 12});       // h equals i with rounding

		// zero sized image drops every point
		set_image_size(0, 0);
		add_step('{0, 0, 0, 0});
		add_step('{10, 10, 5, 2});

		// oversized image saturates to the largest dimension
		set_image_size(8191, 5000);
		add_step('{4095, 4095, 1, 0});
		add_step('{4095, 0, 1023, 0});
		add_step('{0, 4095, 1023, 300});

		// single pixel image
		set_image_size(1, 1);
		add_step('{0, 0, 0, 0});
		add_step('{0, 0, 1, 0});

		// random phase, sender idles less than receiver
		set_image_size(100, 200);
		queue_random(60);

		// random phase, roles swapped, full size image
		set_image_size(4096, 4096);
		tx_idle_pct <= 63;
		rx_idle_pct <= 34;
		queue_random(60);

		// random phase, no idling, random image size
		set_image_size($urandom_range(1, 4096), $urandom_range(1, 4096));
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		queue_random(40);

		// back pressure: receiver holds while the sender keeps offering
		wait_drained();
		hold_req <= 1'b1;
		queue_random(40);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/cperim_pkg.sv
hdl/cperim_sqrt.sv
hdl/cperim_front.sv
hdl/cperim_fifo.sv
hdl/cperim_back.sv
hdl/circle_perimeter_points.sv
tb/tb.sv
